// File: rtl/tso_pkg.sv
// Shared types and widths for the triangle overlap separating-axis pipeline.
// Depends on nothing; every other file imports it.
package tso_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int EDGE_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * EDGE_W;
	localparam int DOT_W       = PROD_W + EDGE_W;
	localparam int PROJ_W      = DOT_W + 2;
	localparam int NUM_AXES    = 11;

	// Action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]      edge_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [DOT_W-1:0]       dot_t;
	typedef logic signed [PROJ_W-1:0]      proj_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} cvec_t;

	typedef struct packed {
		edge_t x;
		edge_t y;
		edge_t z;
	} evec_t;

	typedef struct packed {
		prod_t x;
		prod_t y;
		prod_t z;
	} avec_t;

	// Stage enables handed to the datapath
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Difference of two vertices, one bit wider than a coordinate
	function automatic evec_t vsub(cvec_t a, cvec_t b);
		evec_t r;
		r.x = edge_t'(a.x) - edge_t'(b.x);
		r.y = edge_t'(a.y) - edge_t'(b.y);
		r.z = edge_t'(a.z) - edge_t'(b.z);
		return r;
	endfunction

endpackage

// File: rtl/triangle_overlap_sat_test.sv
// Triangle-triangle overlap test over eleven separating axes.
// A test word passes through stages s1 to s6 and then into the output register.
// Throughput: one word per cycle when the result side is not stalled; a load word yields no result.
// Every axis has its own multiplier lanes, so no multiplier is shared between axes.
// Reset clears all valid bits and sets the reference triangle to all zero.
// Depends on tso_pkg, tso_front, tso_lane.
module triangle_overlap_sat_test import tso_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   tri_valid,
	output logic   tri_ready,
	input  logic   action,
	input  coord_t v1_x,
	input  coord_t v1_y,
	input  coord_t v1_z,
	input  coord_t v2_x,
	input  coord_t v2_y,
	input  coord_t v2_z,
	input  coord_t v3_x,
	input  coord_t v3_y,
	input  coord_t v3_z,
	output logic   res_valid,
	input  logic   res_ready,
	output logic   overlap
);

	cvec_t     tri_v [3];
	evec_t     ea_s1 [3];
	evec_t     eb_s1 [3];
	evec_t     ra_s3 [2];
	evec_t     rb_s3 [3];
	evec_t     lane_u [NUM_AXES];
	evec_t     lane_v [NUM_AXES];
	logic [NUM_AXES-1:0] sep_s6;
	stage_en_t en;
	logic      en_out;
	logic      load;
	logic      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic      res_valid_q;
	logic      overlap_q;

	assign tri_v[0] = '{x: v1_x, y: v1_y, z: v1_z};
	assign tri_v[1] = '{x: v2_x, y: v2_y, z: v2_z};
	assign tri_v[2] = '{x: v3_x, y: v3_y, z: v3_z};

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en_out = !res_valid_q || res_ready;
		en.s6  = !valid_s6 || en_out;
		en.s5  = !valid_s5 || en.s6;
		en.s4  = !valid_s4 || en.s5;
		en.s3  = !valid_s3 || en.s4;
		en.s2  = !valid_s2 || en.s3;
		en.s1  = !valid_s1 || en.s2;
	end

	assign tri_ready = en.s1;
	assign load      = tri_valid && tri_ready && (action == ACT_LOAD);

	// Valid bits travel with the data; only test words enter the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= tri_valid && (action == ACT_TEST);
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
			if (en_out) res_valid_q <= valid_s6;
		end
	end

	tso_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.en     (en),
		.tri_v  (tri_v),
		.ea_s1  (ea_s1),
		.eb_s1  (eb_s1),
		.ra_s3  (ra_s3),
		.rb_s3  (rb_s3)
	);

	// Axis operands: two face normals, then every reference edge with every test edge
	always_comb begin
		lane_u[0] = ea_s1[0];
		lane_v[0] = ea_s1[1];
		lane_u[1] = eb_s1[0];
		lane_v[1] = eb_s1[1];
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				lane_u[2 + 3*i + j] = ea_s1[i];
				lane_v[2 + 3*i + j] = eb_s1[j];
			end
		end
	end

	for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
		tso_lane u_lane (
			.clk    (clk),
			.en     (en),
			.u      (lane_u[k]),
			.v      (lane_v[k]),
			.ra     (ra_s3),
			.rb     (rb_s3),
			.sep_s6 (sep_s6[k])
		);
	end

	// Output register: overlap when no axis separates
	always_ff @(posedge clk) begin
		if (en_out) overlap_q <= ~|sep_s6;
	end

	assign res_valid = res_valid_q;
	assign overlap   = overlap_q;

endmodule

// File: rtl/tso_front.sv
// Front stage: reference triangle storage, edge vectors and vertex offsets.
// Depends on tso_pkg.
module tso_front import tso_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  stage_en_t en,
	input  cvec_t     tri_v [3],
	output evec_t     ea_s1 [3],
	output evec_t     eb_s1 [3],
	output evec_t     ra_s3 [2],
	output evec_t     rb_s3 [3]
);

	cvec_t ref_q [3];
	evec_t ra_s1 [2];
	evec_t rb_s1 [3];
	evec_t ra_s2 [2];
	evec_t rb_s2 [3];

	// Store the reference on a load word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) ref_q[i] <= '0;
		end else if (load) begin
			for (int i = 0; i < 3; i++) ref_q[i] <= tri_v[i];
		end
	end

	// Edges of both triangles and offsets from the reference's first vertex
	always_ff @(posedge clk) begin
		if (en.s1) begin
			ea_s1[0] <= vsub(ref_q[1], ref_q[0]);
			ea_s1[1] <= vsub(ref_q[2], ref_q[1]);
			ea_s1[2] <= vsub(ref_q[0], ref_q[2]);
			eb_s1[0] <= vsub(tri_v[1], tri_v[0]);
			eb_s1[1] <= vsub(tri_v[2], tri_v[1]);
			eb_s1[2] <= vsub(tri_v[0], tri_v[2]);
			ra_s1[0] <= vsub(ref_q[1], ref_q[0]);
			ra_s1[1] <= vsub(ref_q[2], ref_q[0]);
			for (int i = 0; i < 3; i++) rb_s1[i] <= vsub(tri_v[i], ref_q[0]);
		end
	end

	// Delay the offsets to meet the axes
	always_ff @(posedge clk) begin
		if (en.s2) begin
			ra_s2 <= ra_s1;
			rb_s2 <= rb_s1;
		end
		if (en.s3) begin
			ra_s3 <= ra_s2;
			rb_s3 <= rb_s2;
		end
	end

endmodule

// File: rtl/tso_lane.sv
// One candidate axis: cross product, projections, interval separation.
// Depends on tso_pkg; fed by tso_front.
module tso_lane import tso_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  evec_t     u,
	input  evec_t     v,
	input  evec_t     ra [2],
	input  evec_t     rb [3],
	output logic      sep_s6
);

	prod_t prod_s2 [6];
	avec_t axis_s3;
	dot_t  dot_s4 [5][3];
	proj_t proj_s5 [5];
	proj_t a_lo, a_hi, b_lo, b_hi;

	function automatic proj_t pmin(proj_t a, proj_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic proj_t pmax(proj_t a, proj_t b);
		return (a > b) ? a : b;
	endfunction

	// Cross product partial terms
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2[0] <= $signed(u.y) * $signed(v.z);
			prod_s2[1] <= $signed(u.z) * $signed(v.y);
			prod_s2[2] <= $signed(u.z) * $signed(v.x);
			prod_s2[3] <= $signed(u.x) * $signed(v.z);
			prod_s2[4] <= $signed(u.x) * $signed(v.y);
			prod_s2[5] <= $signed(u.y) * $signed(v.x);
		end
	end

	// Axis components; a zero axis yields all-zero projections and never separates
	always_ff @(posedge clk) begin
		if (en.s3) begin
			axis_s3.x <= prod_s2[0] - prod_s2[1];
			axis_s3.y <= prod_s2[2] - prod_s2[3];
			axis_s3.z <= prod_s2[4] - prod_s2[5];
		end
	end

	// Per-component projection terms: two reference offsets, three test offsets
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int i = 0; i < 2; i++) begin
				dot_s4[i][0] <= $signed(axis_s3.x) * $signed(ra[i].x);
				dot_s4[i][1] <= $signed(axis_s3.y) * $signed(ra[i].y);
				dot_s4[i][2] <= $signed(axis_s3.z) * $signed(ra[i].z);
			end
			for (int i = 0; i < 3; i++) begin
				dot_s4[i+2][0] <= $signed(axis_s3.x) * $signed(rb[i].x);
				dot_s4[i+2][1] <= $signed(axis_s3.y) * $signed(rb[i].y);
				dot_s4[i+2][2] <= $signed(axis_s3.z) * $signed(rb[i].z);
			end
		end
	end

	// Sum into projections
	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int i = 0; i < 5; i++) begin
				proj_s5[i] <= proj_t'(dot_s4[i][0]) + proj_t'(dot_s4[i][1])
					+ proj_t'(dot_s4[i][2]);
			end
		end
	end

	// Interval ends; the reference's first vertex projects to zero
	always_comb begin
		a_lo = pmin(pmin('0, proj_s5[0]), proj_s5[1]);
		a_hi = pmax(pmax('0, proj_s5[0]), proj_s5[1]);
		b_lo = pmin(pmin(proj_s5[2], proj_s5[3]), proj_s5[4]);
		b_hi = pmax(pmax(proj_s5[2], proj_s5[3]), proj_s5[4]);
	end

	// Separated only when one interval lies strictly beyond the other
	always_ff @(posedge clk) begin
		if (en.s6) begin
			sep_s6 <= (a_hi < b_lo) || (b_hi < a_lo);
		end
	end

endmodule

// File: bench/tso_checker.sv
`timescale 1ns / 1ps
// Checker for the triangle overlap block: watches both channels, keeps its own
// copy of the reference triangle and predicts each overlap bit. Uses tso_pkg.
module tso_checker import tso_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   tri_valid,
	input  logic   tri_ready,
	input  logic   action,
	input  coord_t v1_x,
	input  coord_t v1_y,
	input  coord_t v1_z,
	input  coord_t v2_x,
	input  coord_t v2_y,
	input  coord_t v2_z,
	input  coord_t v3_x,
	input  coord_t v3_y,
	input  coord_t v3_z,
	input  logic   res_valid,
	input  logic   res_ready,
	input  logic   overlap,
	output int     fail_count,
	output int     pending,
	output int     checked,
	output int     hits
);

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} ivec_t;

	typedef ivec_t [2:0] tri3_t;

	tri3_t      ref_tri;
	tri3_t      probe;
	bit         overlap_due [256];
	logic [7:0] due_wr;
	logic [7:0] due_rd;
	int         due_cnt;
	bit         want;

	function automatic ivec_t diff3(ivec_t a, ivec_t b);
		ivec_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		r.z = a.z - b.z;
		return r;
	endfunction

	function automatic ivec_t cross3(ivec_t a, ivec_t b);
		ivec_t r;
		r.x = a.y * b.z - a.z * b.y;
		r.y = a.z * b.x - a.x * b.z;
		r.z = a.x * b.y - a.y * b.x;
		return r;
	endfunction

	function automatic logic signed [63:0] dot3(ivec_t a, ivec_t b);
		return a.x * b.x + a.y * b.y + a.z * b.z;
	endfunction

	// Project both triangles onto the axis, relative to the first reference vertex;
	// only a strict gap separates, touching intervals do not
	function automatic bit axis_separates(ivec_t ax, tri3_t a, tri3_t b);
		logic signed [63:0] p, alo, ahi, blo, bhi;
		if (ax.x == 0 && ax.y == 0 && ax.z == 0)
			return 1'b0;
		for (int i = 0; i < 3; i++) begin
			p = dot3(ax, diff3(a[i], a[0]));
			if (i == 0 || p < alo) alo = p;
			if (i == 0 || p > ahi) ahi = p;
			p = dot3(ax, diff3(b[i], a[0]));
			if (i == 0 || p < blo) blo = p;
			if (i == 0 || p > bhi) bhi = p;
		end
		return (ahi < blo) || (bhi < alo);
	endfunction

	// Two face normals, then every reference edge crossed with every test edge
	function automatic bit tris_overlap(tri3_t a, tri3_t b);
		ivec_t ea [3];
		ivec_t eb [3];
		for (int i = 0; i < 3; i++) begin
			ea[i] = diff3(a[(i + 1) % 3], a[i]);
			eb[i] = diff3(b[(i + 1) % 3], b[i]);
		end
		if (axis_separates(cross3(ea[0], ea[1]), a, b)) return 1'b0;
		if (axis_separates(cross3(eb[0], eb[1]), a, b)) return 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (axis_separates(cross3(ea[i], eb[j]), a, b)) return 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_tri = '0;
			due_wr  = '0;
			due_rd  = '0;
			due_cnt = 0;
			pending    <= 0;
			fail_count <= 0;
			checked    <= 0;
			hits       <= 0;
		end else begin
			// compare a result word against the oldest prediction
			if (res_valid && res_ready) begin
				if (due_cnt == 0) begin
					$display("%0t: unexpected result word: expected none, actual overlap=%0b",
						$time, overlap);
					fail_count <= fail_count + 1;
				end else begin
					want    = overlap_due[due_rd];
					due_rd  = due_rd + 8'd1;
					due_cnt = due_cnt - 1;
					if (overlap !== want) begin
						$display("%0t: overlap mismatch: expected %0b, actual %0b",
							$time, want, overlap);
						fail_count <= fail_count + 1;
					end
					checked <= checked + 1;
					if (want) hits <= hits + 1;
				end
			end
			// take a triangle word: store it or predict its answer
			if (tri_valid && tri_ready) begin
				probe[0].x = v1_x;
				probe[0].y = v1_y;
				probe[0].z = v1_z;
				probe[1].x = v2_x;
				probe[1].y = v2_y;
				probe[1].z = v2_z;
				probe[2].x = v3_x;
				probe[2].y = v3_y;
				probe[2].z = v3_z;
				if (action == ACT_LOAD) begin
					ref_tri = probe;
				end else begin
					overlap_due[due_wr] = tris_overlap(ref_tri, probe);
					due_wr  = due_wr + 8'd1;
					due_cnt = due_cnt + 1;
				end
			end
			pending <= due_cnt;
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the bench for the triangle overlap block: clock, reset, triangle words
// and result back-pressure. Depends on tso_pkg, tso_checker and triangle_overlap_sat_test.
module testbench;
	import tso_pkg::*;

	localparam int LIMIT    = 400000;
	localparam int HOLD_AT  = 1000;
	localparam int HOLD_LEN = 400;
	localparam int N_RANDOM = 930;

	logic   clk       = 1'b0;
	logic   arst_n    = 1'b0;
	logic   tri_valid = 1'b0;
	logic   tri_ready;
	logic   action    = ACT_LOAD;
	coord_t v1_x = '0, v1_y = '0, v1_z = '0;
	coord_t v2_x = '0, v2_y = '0, v2_z = '0;
	coord_t v3_x = '0, v3_y = '0, v3_z = '0;
	logic   res_valid;
	logic   res_ready = 1'b0;
	logic   overlap;

	int fail_count, pending, checked, hits;
	int cycle_count = 0;
	int loads_sent  = 0;
	int tests_sent  = 0;
	int tv [9];
	int ref_c [9];
	int ref_span = 100;
	bit burst = 1'b0;

	triangle_overlap_sat_test u_dut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready), .action(action),
		.v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
		.v3_x(v3_x), .v3_y(v3_y), .v3_z(v3_z),
		.res_valid(res_valid), .res_ready(res_ready), .overlap(overlap)
	);

	tso_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready), .action(action),
		.v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
		.v3_x(v3_x), .v3_y(v3_y), .v3_z(v3_z),
		.res_valid(res_valid), .res_ready(res_ready), .overlap(overlap),
		.fail_count(fail_count), .pending(pending), .checked(checked), .hits(hits)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog
	initial begin
		wait (cycle_count >= LIMIT);
		$display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
		$display("*** FAILED ***");
		$finish;
	end

	// Idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int jitter(int s);
		int r;
		r = $urandom_range(0, 2 * s);
		return r - s;
	endfunction

	function automatic int clamp16(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int pick_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return $urandom_range(1, 16);
		if (r < 85) return $urandom_range(17, 1000);
		return $urandom_range(1000, 3000);
	endfunction

	// Offer the word held in tv, hold it until taken, then idle for a random gap, none in a burst
	task automatic send_word(input logic act);
		int gap;
		action    <= act;
		v1_x <= tv[0][15:0]; v1_y <= tv[1][15:0]; v1_z <= tv[2][15:0];
		v2_x <= tv[3][15:0]; v2_y <= tv[4][15:0]; v2_z <= tv[5][15:0];
		v3_x <= tv[6][15:0]; v3_y <= tv[7][15:0]; v3_z <= tv[8][15:0];
		tri_valid <= 1'b1;
		do @(posedge clk); while (!tri_ready);
		if (act == ACT_LOAD) begin
			ref_c = tv;
			loads_sent++;
		end else begin
			tests_sent++;
		end
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			tri_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: random stalls, quiet stretches, and one long hold-off
	initial begin
		int rx_cycles;
		int stall_left;
		rx_cycles  = 0;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles == HOLD_AT)
				stall_left = HOLD_LEN;
			else if (stall_left == 0 && (rx_cycles / 500) % 4 != 3 &&
				$urandom_range(0, 99) < 20)
				stall_left = pick_gap();
			res_ready <= (stall_left == 0);
			if (stall_left > 0) stall_left--;
		end
	end

	initial begin
		int kind, s, k, c;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tests against the reset reference, a single point at the origin
		tv = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     send_word(ACT_TEST);
		tv = '{-5, -5, 0, 5, -5, 0, 0, 5, 0};                  send_word(ACT_TEST);
		tv = '{32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767, 32767};
		send_word(ACT_TEST);

		// flat reference in z = 0
		tv = '{0, 0, 0, 100, 0, 0, 0, 100, 0};                 send_word(ACT_LOAD);
		tv = '{0, 0, 0, 100, 0, 0, 0, 100, 0};                 send_word(ACT_TEST);
		// coplanar, touching at one vertex, then one step apart
		tv = '{100, 0, 0, 200, 0, 0, 200, 100, 0};             send_word(ACT_TEST);
		tv = '{101, 0, 0, 200, 0, 0, 200, 100, 0};             send_word(ACT_TEST);
		// piercing, touching the plane, just above it
		tv = '{20, 20, -50, 20, 20, 50, 40, 30, 50};           send_word(ACT_TEST);
		tv = '{2, 2, 0, 2, 2, 10, 5, 5, 10};                   send_word(ACT_TEST);
		tv = '{2, 2, 1, 2, 2, 10, 5, 5, 10};                   send_word(ACT_TEST);
		// degenerate test triangles: points and a segment
		tv = '{10, 10, 0, 10, 10, 0, 10, 10, 0};               send_word(ACT_TEST);
		tv = '{10, 10, 5, 10, 10, 5, 10, 10, 5};               send_word(ACT_TEST);
		tv = '{10, 10, -5, 10, 10, 5, 10, 10, 15};             send_word(ACT_TEST);

		// coordinate extremes
		tv = '{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767};
		send_word(ACT_LOAD);
		tv = '{32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768};
		send_word(ACT_TEST);
		tv = '{32767, 32767, 32767, 32767, 32767, 32766, 32766, 32767, 32767};
		send_word(ACT_TEST);
		tv = '{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767};
		send_word(ACT_TEST);

		// degenerate reference: a single point
		tv = '{5, 5, 5, 5, 5, 5, 5, 5, 5};                     send_word(ACT_LOAD);
		tv = '{0, 0, 5, 10, 0, 5, 0, 10, 5};                   send_word(ACT_TEST);
		tv = '{6, 6, 5, 10, 6, 5, 6, 10, 5};                   send_word(ACT_TEST);
		tv = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     send_word(ACT_LOAD);
		tv = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     send_word(ACT_TEST);
		ref_span = 100;

		// random words, mostly tests built around the current reference
		for (int n = 0; n < N_RANDOM; n++) begin
			burst = ((n / 64) % 4 == 2);
			kind  = $urandom_range(0, 99);
			s     = pick_span();
			if (kind < 12) begin
				if ($urandom_range(0, 3) == 0) begin
					for (int i = 0; i < 9; i++) tv[i] = $urandom();
					ref_span = pick_span();
				end else begin
					for (int i = 0; i < 3; i++) begin
						c = jitter(30000);
						for (int j = 0; j < 3; j++) tv[3 * j + i] = clamp16(c + jitter(s));
					end
					// flat reference so coplanar tests line up with it
					if ($urandom_range(0, 3) == 0) begin
						tv[5] = tv[2];
						tv[8] = tv[2];
					end
					ref_span = s;
				end
				send_word(ACT_LOAD);
			end else begin
				if (kind < 72) begin
					for (int j = 0; j < 3; j++) begin
						k = $urandom_range(0, 2);
						for (int i = 0; i < 3; i++)
							tv[3 * j + i] = clamp16(ref_c[3 * k + i] + jitter(ref_span));
					end
					if (kind >= 45 && kind < 60) begin
						tv[2] = ref_c[2];
						tv[5] = ref_c[2];
						tv[8] = ref_c[2];
					end else if (kind >= 60) begin
						// share one reference vertex exactly
						k = $urandom_range(0, 2);
						for (int i = 0; i < 3; i++) tv[i] = ref_c[3 * k + i];
					end
				end else if (kind < 84) begin
					for (int i = 0; i < 3; i++) begin
						tv[i]     = clamp16(ref_c[i] + jitter(ref_span));
						tv[3 + i] = clamp16(tv[i] + jitter(ref_span));
						tv[6 + i] = ($urandom_range(0, 1) == 0) ? tv[i] :
							clamp16(2 * tv[3 + i] - tv[i]);
					end
				end else begin
					for (int i = 0; i < 9; i++) tv[i] = $urandom();
				end
				send_word(ACT_TEST);
			end
		end
		burst = 1'b0;
		tri_valid <= 1'b0;

		// drain
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d reference loads and %0d overlap tests in %0d cycles.",
			loads_sent, tests_sent, cycle_count);
		$display("Checked %0d results, %0d overlapping, %0d failures.",
			checked, hits, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
